[rtl/token_scanner_assert.svh]
`ifndef TOKEN_SCANNER_ASSERT_SVH
`define TOKEN_SCANNER_ASSERT_SVH
// implication checked on every edge out of reset
`define TS_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// implication with the consequent checked in the next cycle
`define TS_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

[rtl/tsc_pkg.sv]
package tsc_pkg;

  localparam int unsigned COMMENT_DEPTH_MAX = 15;
  localparam int unsigned KEYWORD_CHARS = 9;
  localparam int unsigned NUM_KEYWORDS = 20;
  localparam logic [15:0] LEN_MAX = 16'hFFFF;
  localparam logic [62:0] MASK63 = {63{1'b1}};
  // decimal overflow bound: acc * 10 + d fits iff acc < LIMIT or (acc == LIMIT and d <= REM)
  localparam logic [62:0] DEC_LIMIT = MASK63 / 63'd10;
  localparam logic [62:0] DEC_REM = MASK63 % 63'd10;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } tsc_in_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [3:0]  error_code;
    logic [62:0] int_value;
    logic [31:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;
  } tsc_out_t;

  typedef enum logic [3:0] {
    M_IDLE, M_WORD, M_REAL, M_COLON, M_LPAREN, M_COMMENT, M_CSTAR, M_CLPAREN
  } scan_mode_t;

  typedef enum logic [2:0] {
    R_INT, R_FRAC, R_ESTART, R_ESIGN, R_EDIG, R_BAD5, R_BAD7
  } real_check_t;

  localparam logic [5:0] K_EOF = 6'd0;
  localparam logic [5:0] K_IDENT = 6'd1;
  localparam logic [5:0] K_INT = 6'd2;
  localparam logic [5:0] K_REAL = 6'd3;
  localparam logic [5:0] K_KW0 = 6'd4;
  localparam logic [5:0] K_SEMI = 6'd24;
  localparam logic [5:0] K_DOT = 6'd25;
  localparam logic [5:0] K_BECOMES = 6'd26;
  localparam logic [5:0] K_COLON = 6'd27;
  localparam logic [5:0] K_COMMA = 6'd28;
  localparam logic [5:0] K_TIMES = 6'd29;
  localparam logic [5:0] K_EQUAL = 6'd30;
  localparam logic [5:0] K_PLUS = 6'd31;
  localparam logic [5:0] K_MINUS = 6'd32;
  localparam logic [5:0] K_SLASH = 6'd33;
  localparam logic [5:0] K_AND = 6'd34;
  localparam logic [5:0] K_LPAREN = 6'd35;
  localparam logic [5:0] K_RPAREN = 6'd36;
  localparam logic [5:0] K_ERROR = 6'd37;

  localparam logic [3:0] E_NONE = 4'd0;
  localparam logic [3:0] E_BADCHAR = 4'd1;
  localparam logic [3:0] E_DECDIG = 4'd2;
  localparam logic [3:0] E_HEXDIG = 4'd3;
  localparam logic [3:0] E_REALDOT = 4'd4;
  localparam logic [3:0] E_REALE = 4'd5;
  localparam logic [3:0] E_REALEXP = 4'd6;
  localparam logic [3:0] E_REALCH = 4'd7;
  localparam logic [3:0] E_EOFCMT = 4'd8;
  localparam logic [3:0] E_NEST = 4'd9;
  localparam logic [3:0] E_OVERFLOW = 4'd10;

  typedef logic [KEYWORD_CHARS*8-1:0] kw_t;

  // spelling packed first char at the low byte, length alongside
  function automatic kw_t kw_text(input int unsigned i);
    kw_t t;
    t = '0;
    unique case (i)
      0: t = kw_t'("NIGEB");
      1: t = kw_t'("TSNOC");
      2: t = kw_t'("VID");
      3: t = kw_t'("OD");
      4: t = kw_t'("ESLE");
      5: t = kw_t'("FISLE");
      6: t = kw_t'("DNE");
      7: t = kw_t'("ESLAF");
      8: t = kw_t'("FI");
      9: t = kw_t'("TROPMI");
      10: t = kw_t'("DOM");
      11: t = kw_t'("ELUDOM");
      12: t = kw_t'("LIN");
      13: t = kw_t'("ERUDECORP");
      14: t = kw_t'("RO");
      15: t = kw_t'("NEHT");
      16: t = kw_t'("EURT");
      17: t = kw_t'("EPYT");
      18: t = kw_t'("RAV");
      default: t = kw_t'("ELIHW");
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input int unsigned i);
    logic [3:0] n;
    unique case (i)
      0, 1, 7, 19: n = 4'd5;
      2, 6, 10, 12, 18: n = 4'd3;
      3, 8, 14: n = 4'd2;
      4, 15, 16, 17: n = 4'd4;
      5: n = 4'd5;
      9, 11: n = 4'd6;
      13: n = 4'd9;
      default: n = 4'd5;
    endcase
    return n;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

endpackage

[rtl/token_scanner.sv]
// output: results of an accepted beat are registered straight into the output register
// throughput: one input beat per cycle while the output is taken; a beat causing two
//   results keeps the second in the extra slot, and input is held off while it waits
// reset: rst_n synchronous, active low; scanner idle, position zero, not halted
module token_scanner (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tsc_pkg::tsc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tsc_pkg::tsc_out_t out_data
);
  import tsc_pkg::*;
  `include "token_scanner_assert.svh"

  scan_mode_t  mode_r, mode_nxt;
  real_check_t rc_r, rc_nxt;
  kw_t         ident_r, ident_nxt;
  logic [15:0] len_r, len_nxt;
  logic [62:0] dec_r, dec_nxt, hex_r, hex_nxt;
  logic        dov_r, dov_nxt, hov_r, hov_nxt;
  logic        f_nondec_r, f_nondec_nxt, f_badhex_r, f_badhex_nxt;
  logic        f_lasth_r, f_lasth_nxt, f_digit_r, f_digit_nxt;
  logic [3:0]  fault_r, fault_nxt;
  logic [3:0]  depth_r, depth_nxt;
  logic [31:0] pos_r, pos_nxt, start_r, start_nxt;
  logic        halt_r, halt_nxt;

  // output: main register plus a second slot for the second result
  tsc_out_t o0_r, o1_r;
  logic     v0_r, v1_r;

  logic       kw_hit;
  logic [4:0] kw_idx;

  tsc_keyword_match u_kw (
    .chars   (ident_r),
    .run_len (len_r),
    .hit     (kw_hit),
    .index   (kw_idx)
  );

  logic     acc;
  tsc_out_t r [2];
  logic [1:0] n;
  logic [7:0] c;

  assign in_ready = !v1_r && (!v0_r || out_ready);
  assign acc = in_valid && in_ready;
  assign c = in_data.char_code;

  always_comb begin
    logic [62:0] d;
    logic [3:0]  k_fault;
    logic        emit_tok;
    logic [5:0]  tk;
    logic [62:0] tv;
    logic        do_idle;

    mode_nxt = mode_r; rc_nxt = rc_r; ident_nxt = ident_r; len_nxt = len_r;
    dec_nxt = dec_r; hex_nxt = hex_r; dov_nxt = dov_r; hov_nxt = hov_r;
    f_nondec_nxt = f_nondec_r; f_badhex_nxt = f_badhex_r;
    f_lasth_nxt = f_lasth_r; f_digit_nxt = f_digit_r;
    fault_nxt = fault_r; depth_nxt = depth_r; pos_nxt = pos_r;
    start_nxt = start_r; halt_nxt = halt_r;
    n = '0;
    r[0] = '0; r[1] = '0;
    d = '0; k_fault = E_NONE; emit_tok = 1'b0;
    tk = K_EOF; tv = '0; do_idle = 1'b0;

    // pending token on termination (word, real)
    if (!halt_r && (in_data.end_of_input || !(
        (mode_r == M_WORD && (is_alnum(c) || (c == "." && f_digit_r))) ||
        (mode_r == M_REAL && (c == "." || is_digit(c) || c == "+" || c == "-" || c == "E")))))
    begin
      if (mode_r == M_WORD) begin
        emit_tok = 1'b1; tv = '0;
        if (len_r <= 16'(KEYWORD_CHARS) && kw_hit) tk = K_KW0 + 6'(kw_idx);
        else if (!f_digit_r) tk = K_IDENT;
        else if (f_lasth_r) begin
          if (f_badhex_r) k_fault = E_HEXDIG;
          else if (hov_r) k_fault = E_OVERFLOW;
          else begin tk = K_INT; tv = hex_r; end
        end else begin
          if (f_nondec_r) k_fault = E_DECDIG;
          else if (dov_r) k_fault = E_OVERFLOW;
          else begin tk = K_INT; tv = dec_r; end
        end
      end else if (mode_r == M_REAL) begin
        emit_tok = 1'b1; tk = K_REAL;
        if (f_nondec_r) k_fault = E_REALDOT;
        else begin
          unique case (rc_r)
            R_FRAC, R_EDIG: k_fault = E_NONE;
            R_ESTART, R_ESIGN: k_fault = E_REALEXP;
            R_BAD5: k_fault = E_REALE;
            default: k_fault = E_REALCH;
          endcase
        end
      end
    end

    if (halt_r) begin
      r[0] = '{K_ERROR, fault_r, 63'd0, start_r, len_r, 1'b0};
      n = 2'd1;
    end else if (emit_tok) begin
      if (k_fault != E_NONE) begin
        r[0] = '{K_ERROR, k_fault, 63'd0, start_r, len_r, 1'b0};
        n = 2'd1; halt_nxt = 1'b1; fault_nxt = k_fault;
      end else begin
        r[0] = '{tk, E_NONE, tv, start_r, len_r, 1'b0};
        n = 2'd1;
        if (in_data.end_of_input) begin
          r[1] = '{K_EOF, E_NONE, 63'd0, pos_r, 16'd0, 1'b0};
          n = 2'd2; mode_nxt = M_IDLE;
        end else do_idle = 1'b1;
      end
      if (!in_data.end_of_input) pos_nxt = pos_r + 32'd1;
    end else if (in_data.end_of_input) begin
      unique case (mode_r)
        M_COLON, M_LPAREN: begin
          r[0] = '{(mode_r == M_COLON) ? K_COLON : K_LPAREN, E_NONE, 63'd0, start_r,
                   16'd1, 1'b0};
          r[1] = '{K_EOF, E_NONE, 63'd0, pos_r, 16'd0, 1'b0};
          n = 2'd2; mode_nxt = M_IDLE;
        end
        M_COMMENT, M_CSTAR, M_CLPAREN: begin
          r[0] = '{K_ERROR, E_EOFCMT, 63'd0, start_r, len_r, 1'b0};
          n = 2'd1; halt_nxt = 1'b1; fault_nxt = E_EOFCMT;
        end
        default: begin
          r[0] = '{K_EOF, E_NONE, 63'd0, pos_r, 16'd0, 1'b0};
          n = 2'd1; mode_nxt = M_IDLE;
        end
      endcase
    end else begin
      pos_nxt = pos_r + 32'd1;
      unique case (mode_r)
        M_WORD: begin
          if (is_alnum(c)) begin
            // add char to the running word
            if (len_r < 16'(KEYWORD_CHARS)) ident_nxt[len_r[3:0]*8 +: 8] = c;
            if (len_r != LEN_MAX) len_nxt = len_r + 16'd1;
            f_lasth_nxt = 1'b0;
            if (f_lasth_r) f_badhex_nxt = 1'b1;
            if (is_digit(c)) begin
              d = 63'(c - 8'h30);
              if (!dov_r) begin
                if (dec_r > DEC_LIMIT || (dec_r == DEC_LIMIT && d > DEC_REM)) dov_nxt = 1'b1;
                else dec_nxt = 63'(dec_r * 10) + d;
              end
              if (!hov_r) begin
                if (hex_r > ((MASK63 - d) >> 4)) hov_nxt = 1'b1;
                else hex_nxt = {hex_r[58:0], 4'h0} + d;
              end
            end else begin
              f_nondec_nxt = 1'b1;
              if (c >= "A" && c <= "F") begin
                d = 63'(c - 8'h37);
                if (!hov_r) begin
                  if (hex_r > ((MASK63 - d) >> 4)) hov_nxt = 1'b1;
                  else hex_nxt = {hex_r[58:0], 4'h0} + d;
                end
              end else if (c == "H") f_lasth_nxt = 1'b1;
              else f_badhex_nxt = 1'b1;
            end
          end else begin
            mode_nxt = M_REAL; rc_nxt = R_FRAC;
            if (len_r != LEN_MAX) len_nxt = len_r + 16'd1;
          end
        end
        M_REAL: begin
          unique case (rc_r)
            R_INT: if (c == ".") rc_nxt = R_FRAC; else if (!is_digit(c)) rc_nxt = R_BAD5;
            R_FRAC: if (c == "E") rc_nxt = R_ESTART; else if (!is_digit(c)) rc_nxt = R_BAD5;
            R_ESTART:
              if (c == "+" || c == "-") rc_nxt = R_ESIGN;
              else rc_nxt = is_digit(c) ? R_EDIG : R_BAD7;
            R_ESIGN, R_EDIG: rc_nxt = is_digit(c) ? R_EDIG : R_BAD7;
            default: rc_nxt = rc_r;
          endcase
          if (len_r != LEN_MAX) len_nxt = len_r + 16'd1;
        end
        M_COLON: begin
          if (c == "=") begin
            r[0] = '{K_BECOMES, E_NONE, 63'd0, start_r, 16'd2, 1'b0};
            n = 2'd1; mode_nxt = M_IDLE;
          end else begin
            r[0] = '{K_COLON, E_NONE, 63'd0, start_r, 16'd1, 1'b0};
            n = 2'd1; do_idle = 1'b1;
          end
        end
        M_LPAREN: begin
          if (c == "*") begin
            mode_nxt = M_COMMENT; depth_nxt = 4'd1; len_nxt = 16'd2;
          end else begin
            r[0] = '{K_LPAREN, E_NONE, 63'd0, start_r, 16'd1, 1'b0};
            n = 2'd1; do_idle = 1'b1;
          end
        end
        M_COMMENT, M_CSTAR, M_CLPAREN: begin
          if (len_r != LEN_MAX) len_nxt = len_r + 16'd1;
          if (c == "(") mode_nxt = M_CLPAREN;
          else if (c == "*" && mode_r == M_CLPAREN) begin
            if (depth_r >= 4'(COMMENT_DEPTH_MAX)) begin
              r[0] = '{K_ERROR, E_NEST, 63'd0, start_r, len_nxt, 1'b0};
              n = 2'd1; halt_nxt = 1'b1; fault_nxt = E_NEST;
            end else begin
              depth_nxt = depth_r + 4'd1; mode_nxt = M_COMMENT;
            end
          end else if (c == "*") mode_nxt = M_CSTAR;
          else if (c == ")" && mode_r == M_CSTAR) begin
            depth_nxt = (depth_r > 4'd0) ? depth_r - 4'd1 : 4'd0;
            mode_nxt = (depth_nxt == 4'd0) ? M_IDLE : M_COMMENT;
          end else mode_nxt = M_COMMENT;
        end
        default: do_idle = 1'b1;
      endcase
    end

    // idle handling of a byte, possibly appended after a first result
    if (do_idle) begin
      mode_nxt = M_IDLE;
      if (c > 8'h20) begin
        if (is_alnum(c)) begin
          mode_nxt = M_WORD; start_nxt = pos_r; len_nxt = 16'd1;
          dec_nxt = '0; hex_nxt = '0; dov_nxt = 1'b0; hov_nxt = 1'b0;
          rc_nxt = R_INT;
          f_digit_nxt = is_digit(c); f_nondec_nxt = !is_digit(c);
          f_lasth_nxt = (c == "H"); f_badhex_nxt = 1'b0;
          ident_nxt[7:0] = c;
          if (is_digit(c)) begin
            dec_nxt = 63'(c - 8'h30); hex_nxt = 63'(c - 8'h30);
          end else if (c >= "A" && c <= "F") hex_nxt = 63'(c - 8'h37);
          else if (c != "H") f_badhex_nxt = 1'b1;
        end else if (c == ":" || c == "(") begin
          mode_nxt = (c == ":") ? M_COLON : M_LPAREN;
          start_nxt = pos_r; len_nxt = 16'd1;
        end else begin
          unique case (c)
            ";": tk = K_SEMI;
            ".": tk = K_DOT;
            ",": tk = K_COMMA;
            "*": tk = K_TIMES;
            "=": tk = K_EQUAL;
            "+": tk = K_PLUS;
            "-": tk = K_MINUS;
            "/": tk = K_SLASH;
            "&": tk = K_AND;
            ")": tk = K_RPAREN;
            default: tk = K_ERROR;
          endcase
          if (tk == K_ERROR) begin
            start_nxt = pos_r; len_nxt = 16'd1;
            halt_nxt = 1'b1; fault_nxt = E_BADCHAR;
            r[n[0]] = '{K_ERROR, E_BADCHAR, 63'd0, pos_r, 16'd1, 1'b0};
          end else r[n[0]] = '{tk, E_NONE, 63'd0, pos_r, 16'd1, 1'b0};
          n = n + 2'd1;
        end
      end
    end

    if (n == 2'd2) r[1].last_of_run = 1'b1;
    else r[0].last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; rc_r <= R_INT; len_r <= '0; dec_r <= '0; hex_r <= '0;
      dov_r <= 1'b0; hov_r <= 1'b0; f_nondec_r <= 1'b0; f_badhex_r <= 1'b0;
      f_lasth_r <= 1'b0; f_digit_r <= 1'b0; fault_r <= E_NONE; depth_r <= '0;
      pos_r <= '0; start_r <= '0; halt_r <= 1'b0; v0_r <= 1'b0; v1_r <= 1'b0;
    end else begin
      if (acc) begin
        mode_r <= mode_nxt; rc_r <= rc_nxt; len_r <= len_nxt; dec_r <= dec_nxt;
        hex_r <= hex_nxt; dov_r <= dov_nxt; hov_r <= hov_nxt;
        f_nondec_r <= f_nondec_nxt; f_badhex_r <= f_badhex_nxt;
        f_lasth_r <= f_lasth_nxt; f_digit_r <= f_digit_nxt; fault_r <= fault_nxt;
        depth_r <= depth_nxt; pos_r <= pos_nxt; start_r <= start_nxt;
        halt_r <= halt_nxt;
      end
      if (acc) begin
        v0_r <= n != 2'd0;
        v1_r <= n == 2'd2;
      end else if (out_valid && out_ready) begin
        if (v1_r) v1_r <= 1'b0;
        else v0_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (acc) begin
      ident_r <= ident_nxt;
      o0_r <= r[0];
      o1_r <= r[1];
    end else if (out_valid && out_ready && v1_r) begin
      o0_r <= o1_r;
    end
  end

  assign out_valid = v0_r;
  assign out_data = o0_r;

  `TS_ASSERT_IMP(a_second_needs_first, v1_r, v0_r)
  `TS_ASSERT_IMP(a_no_accept_with_pair, v1_r, !in_ready)
  `TS_ASSERT_NXT(a_halt_sticks, halt_r, halt_r)
  `TS_ASSERT_IMP(a_depth_bound, 1'b1, depth_r <= 4'(COMMENT_DEPTH_MAX))

endmodule

[rtl/tsc_keyword_match.sv]
module tsc_keyword_match (
  input  tsc_pkg::kw_t        chars,
  input  logic [15:0]         run_len,
  output logic                hit,
  output logic [4:0]          index
);
  import tsc_pkg::*;

  logic [7:0] c_byte [KEYWORD_CHARS];
  logic [NUM_KEYWORDS-1:0] m;

  always_comb begin
    kw_t        kt;
    logic [3:0] kl;
    kt = '0;
    kl = '0;
    for (int i = 0; i < KEYWORD_CHARS; i++) c_byte[i] = chars[i*8 +: 8];
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      kt = kw_text(k);
      kl = kw_len(k);
      m[k] = (run_len == {12'd0, kl});
      for (int i = 0; i < KEYWORD_CHARS; i++) begin
        if (i < kl && c_byte[i] != kt[i*8 +: 8]) m[k] = 1'b0;
      end
    end
  end

  always_comb begin
    index = '0;
    for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
      if (m[k]) index = 5'(k);
    end
  end

  assign hit = |m;

endmodule
